// File: rtl/core/tswr_pkg.sv
// shared types, codes and constants of the tcp sender window / retransmit unit
package tswr_pkg;

   // request command codes
   localparam logic [2:0] CMD_WRITE = 3'd0;
   localparam logic [2:0] CMD_END   = 3'd1;
   localparam logic [2:0] CMD_ACK   = 3'd2;
   localparam logic [2:0] CMD_TICK  = 3'd3;
   localparam logic [2:0] CMD_FILL  = 3'd4;
   localparam logic [2:0] CMD_EMPTY = 3'd5;

   // register indexes
   localparam logic REG_ISN     = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam int          RESULT_LIMIT  = 48;
   localparam int          NSEG_W        = 6;
   localparam logic [17:0] INFLIGHT_MAX  = 18'd131072;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_END,
      OP_ACK,
      OP_TICK,
      OP_FILL,
      OP_EMPTY,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ACK_UNWRAP,
      ST_ACK_APPLY,
      ST_ACK_READ,
      ST_ACK_CHECK,
      ST_FILL
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [16:0] write_count;
      logic [31:0] ack_seqno;
      logic [15:0] ack_window;
      logic [31:0] elapsed_ms;
   } item_type;

   typedef struct packed {
      logic        seg_valid;
      logic [31:0] seg_seqno;
      logic [63:0] seg_offset;
      logic [10:0] seg_payload_len;
      logic        seg_syn;
      logic        seg_fin;
      logic [16:0] accepted_bytes;
      logic [17:0] in_flight;
      logic [15:0] retx_count;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [63:0] offset;
      logic [15:0] plen;
      logic        syn;
      logic        fin;
   } qentry_type;

   typedef struct packed {
      logic        timeout_wr;
      logic [15:0] timeout_wdata;
      logic [31:0] isn;
      logic [15:0] timeout;
   } csr_type;

   function automatic result_type status_result(logic [16:0] accepted, logic [17:0] inflight,
                                                logic [15:0] retx);
      result_type r;
      r = '0;
      r.accepted_bytes = accepted;
      r.in_flight      = inflight;
      r.retx_count     = retx;
      r.last           = 1'b1;
      return r;
   endfunction

endpackage

// File: rtl/core/tswr_front.sv
// front end: accepts requests, decodes the command and buffers them in a short queue
module tswr_front import tswr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [16:0] req_write_count,
   input  logic [31:0] req_ack_seqno,
   input  logic [15:0] req_ack_window,
   input  logic [31:0] req_elapsed_ms,
   input  logic        item_pop,
   output logic        item_valid,
   output item_type    item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   logic       pop;
   item_type   dec;

   always_comb begin
      dec             = '0;
      dec.write_count = req_write_count;
      dec.ack_seqno   = req_ack_seqno;
      dec.ack_window  = req_ack_window;
      dec.elapsed_ms  = req_elapsed_ms;
      case (req_cmd)
         CMD_WRITE: dec.op = OP_WRITE;
         CMD_END:   dec.op = OP_END;
         CMD_ACK:   dec.op = OP_ACK;
         CMD_TICK:  dec.op = OP_TICK;
         CMD_FILL:  dec.op = OP_FILL;
         CMD_EMPTY: dec.op = OP_EMPTY;
         default:   dec.op = OP_NONE;
      endcase
   end

   assign req_stall  = (cnt_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (cnt_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("request queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |=> cnt_ff <= 2'd1)
      else $error("request queue underflow");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("request queue pointers disagree with count");
`endif

endmodule

// File: rtl/core/tswr_engine.sv
// back end: sender state, segment queue, ack / tick / fill sequencing and result register
module tswr_engine import tswr_pkg::*; #(
   parameter int MAX_PAYLOAD     = 1452,
   parameter int STREAM_CAPACITY = 65536,
   parameter int QUEUE_DEPTH     = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  csr_type    csr,
   input  logic       item_valid,
   input  item_type   item,
   output logic       item_pop,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   localparam int SFW = $clog2(STREAM_CAPACITY + 1);
   localparam int MW  = (SFW > 17) ? SFW : 17;
   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [SFW-1:0] CAP     = SFW'(STREAM_CAPACITY);
   localparam logic [MW-1:0]  MAXP    = MW'(MAX_PAYLOAD);
   localparam logic [QCW:0]   DEPTH_X = (QCW + 1)'(QUEUE_DEPTH);

   state_type state_ff, state_in;
   item_type  item_ff, item_in;
   logic [63:0] next_ff, next_in;
   logic [63:0] acked_ff, acked_in;
   logic [15:0] win_ff, win_in;
   logic [17:0] outst_ff, outst_in;
   logic [SFW-1:0] fill_ff, fill_in;
   logic ended_ff, ended_in;
   logic fin_ff, fin_in;
   logic trun_ff, trun_in;
   logic [31:0] tleft_ff, tleft_in;
   logic [31:0] tcur_ff, tcur_in;
   logic [15:0] retx_ff, retx_in;
   logic [QAW-1:0] head_ff, head_in;
   logic [QCW-1:0] count_ff, count_in;
   logic [31:0] off_ff, off_in;
   logic [63:0] abs_ff, abs_in;
   logic [63:0] wend_ff, wend_in;
   logic [NSEG_W-1:0] nseg_ff, nseg_in;
   result_type hold_ff, hold_in;
   logic hold_vld_ff, hold_vld_in;
   result_type out_ff;
   logic out_vld_ff;
   logic out_load;
   result_type out_next;

   qentry_type mem [QUEUE_DEPTH];
   qentry_type mem_rd_ff;
   logic mem_we;
   qentry_type mem_wd;
   logic [QAW-1:0] tail;
   logic [QCW:0] tail_sum;

   logic out_free;
   logic fill_cont;
   logic [16:0] room;
   logic        syn;
   logic [16:0] avail;
   logic [MW-1:0] take_a, take_b, take_c;
   logic [15:0] take;
   logic [SFW-1:0] fill_after;
   logic        fin_now;
   logic [16:0] seglen;
   logic [18:0] outst_sum;
   logic [17:0] outst_add;
   logic [SFW-1:0] freeb;
   logic [MW-1:0]  acc_w;
   logic [16:0] acc;
   logic [31:0] nlo, nhi, dlt;
   logic [63:0] cand;
   logic [16:0] elen;
   logic [63:0] ent_end;
   logic        ent_break;
   logic        ack_beyond;
   logic        tick_live;
   logic        tick_fire;
   logic [15:0] retx_fire;
   logic [31:0] tcur_fire;
   logic [15:0] win_eff;

   assign out_free  = !out_vld_ff || !out_stall;
   assign out_valid = out_vld_ff;
   assign out_data  = out_ff;

   // queue tail
   assign tail_sum = {{(QCW + 1 - QAW){1'b0}}, head_ff} + {1'b0, count_ff};
   assign tail = (tail_sum >= DEPTH_X) ? QAW'(tail_sum - DEPTH_X) : QAW'(tail_sum);

   // one segment cut
   assign win_eff   = (win_ff == 16'd0) ? 16'd1 : win_ff;
   assign fill_cont = !fin_ff && (next_ff < wend_ff) && (nseg_ff < NSEG_W'(RESULT_LIMIT)) &&
                      (count_ff < QCW'(QUEUE_DEPTH)) &&
                      (fill_ff != '0 || next_ff == 64'd0 || ended_ff);
   assign room    = wend_ff[16:0] - next_ff[16:0];
   assign syn     = (next_ff == 64'd0);
   assign avail   = room - {16'd0, syn};
   assign take_a  = MW'(avail);
   assign take_b  = (MW'(fill_ff) < take_a) ? MW'(fill_ff) : take_a;
   assign take_c  = (MAXP < take_b) ? MAXP : take_b;
   assign take    = take_c[15:0];
   assign fill_after = fill_ff - SFW'(take);
   assign fin_now = ({1'b0, take} + {16'd0, syn} < room) && ended_ff && (fill_after == '0);
   assign seglen  = {1'b0, take} + {16'd0, syn} + {16'd0, fin_now};
   assign outst_sum = {1'b0, outst_ff} + {2'b0, seglen};
   assign outst_add = (outst_sum > {1'b0, INFLIGHT_MAX}) ? INFLIGHT_MAX : outst_sum[17:0];

   // write acceptance
   assign freeb = CAP - fill_ff;
   assign acc_w = ended_ff ? '0 :
                  ((MW'(item_ff.write_count) < MW'(freeb)) ? MW'(item_ff.write_count)
                                                          : MW'(freeb));
   assign acc   = acc_w[16:0];

   // ack unwrap against next_abs_seqno
   assign nlo = next_ff[31:0];
   assign nhi = next_ff[63:32];
   always_comb begin
      cand = {nhi, off_ff};
      if (off_ff > nlo) begin
         dlt = off_ff - nlo;
         if (dlt > 32'h8000_0000 && nhi != 32'd0) begin
            cand = {nhi - 32'd1, off_ff};
         end
      end else begin
         dlt = nlo - off_ff;
         if (dlt > 32'h8000_0000 && nhi != 32'hFFFF_FFFF) begin
            cand = {nhi + 32'd1, off_ff};
         end
      end
   end

   assign ack_beyond = abs_ff > next_ff;
   assign elen      = {1'b0, mem_rd_ff.plen} + {16'd0, mem_rd_ff.syn} + {16'd0, mem_rd_ff.fin};
   assign ent_end   = mem_rd_ff.offset + {47'd0, elen};
   assign ent_break = ent_end > abs_ff;

   // timer
   assign tick_live = trun_ff && (count_ff != '0);
   assign tick_fire = tick_live && (tleft_ff <= item_ff.elapsed_ms);
   assign retx_fire = (win_ff != 16'd0 && retx_ff != 16'hFFFF) ? retx_ff + 16'd1 : retx_ff;
   assign tcur_fire = (win_ff == 16'd0) ? tcur_ff :
                      (tcur_ff > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : {tcur_ff[30:0], 1'b0};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (item_ff.op)
               OP_ACK:  state_in = ST_ACK_UNWRAP;
               OP_FILL: state_in = ST_FILL;
               default: if (out_free) state_in = ST_IDLE;
            endcase
         end
         ST_ACK_UNWRAP: state_in = ST_ACK_APPLY;
         ST_ACK_APPLY: begin
            if (!ack_beyond) state_in = ST_ACK_READ;
            else if (out_free) state_in = ST_IDLE;
         end
         ST_ACK_READ: state_in = ST_ACK_CHECK;
         ST_ACK_CHECK: begin
            if (count_ff != '0 && !ent_break) state_in = ST_ACK_READ;
            else if (out_free) state_in = ST_IDLE;
         end
         ST_FILL: begin
            if (!fill_cont && out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and result
   always_comb begin
      item_in     = item_ff;
      next_in     = next_ff;
      acked_in    = acked_ff;
      win_in      = win_ff;
      outst_in    = outst_ff;
      fill_in     = fill_ff;
      ended_in    = ended_ff;
      fin_in      = fin_ff;
      trun_in     = trun_ff;
      tleft_in    = tleft_ff;
      tcur_in     = tcur_ff;
      retx_in     = retx_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      off_in      = off_ff;
      abs_in      = abs_ff;
      wend_in     = wend_ff;
      nseg_in     = nseg_ff;
      hold_in     = hold_ff;
      hold_vld_in = hold_vld_ff;
      item_pop    = 1'b0;
      out_load    = 1'b0;
      out_next    = status_result(17'd0, outst_ff, retx_ff);
      mem_we      = 1'b0;
      mem_wd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
            end
         end
         ST_EXEC: begin
            case (item_ff.op)
               OP_WRITE: begin
                  if (out_free) begin
                     fill_in  = fill_ff + SFW'(acc);
                     out_load = 1'b1;
                     out_next = status_result(acc, outst_ff, retx_ff);
                  end
               end
               OP_END: begin
                  if (out_free) begin
                     ended_in = 1'b1;
                     out_load = 1'b1;
                  end
               end
               OP_EMPTY: begin
                  if (out_free) begin
                     out_load = 1'b1;
                     out_next.seg_valid  = 1'b1;
                     out_next.seg_offset = next_ff;
                     out_next.seg_seqno  = next_ff[31:0] + csr.isn;
                  end
               end
               OP_ACK: off_in = item_ff.ack_seqno - csr.isn;
               OP_FILL: begin
                  wend_in     = acked_ff + {48'd0, win_eff};
                  nseg_in     = '0;
                  hold_vld_in = 1'b0;
               end
               OP_TICK: begin
                  if (out_free) begin
                     out_load = 1'b1;
                     if (tick_fire) begin
                        retx_in  = retx_fire;
                        tcur_in  = tcur_fire;
                        tleft_in = tcur_fire;
                        out_next = status_result(17'd0, outst_ff, retx_fire);
                        out_next.seg_valid       = 1'b1;
                        out_next.seg_offset      = mem_rd_ff.offset;
                        out_next.seg_seqno       = mem_rd_ff.offset[31:0] + csr.isn;
                        out_next.seg_payload_len = mem_rd_ff.plen[10:0];
                        out_next.seg_syn         = mem_rd_ff.syn;
                        out_next.seg_fin         = mem_rd_ff.fin;
                     end else if (tick_live) begin
                        tleft_in = tleft_ff - item_ff.elapsed_ms;
                     end
                  end
               end
               default: begin
                  if (out_free) out_load = 1'b1;
               end
            endcase
         end
         ST_ACK_UNWRAP: abs_in = cand;
         ST_ACK_APPLY: begin
            if (!ack_beyond) begin
               acked_in = abs_ff;
               win_in   = item_ff.ack_window;
               retx_in  = 16'd0;
            end else if (out_free) begin
               out_load = 1'b1;
            end
         end
         ST_ACK_CHECK: begin
            if (count_ff != '0 && !ent_break) begin
               tleft_in = {16'd0, csr.timeout};
               tcur_in  = {16'd0, csr.timeout};
               outst_in = (outst_ff > {1'b0, elen}) ? outst_ff - {1'b0, elen} : 18'd0;
               head_in  = (head_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + QAW'(1);
               count_in = count_ff - QCW'(1);
            end else if (out_free) begin
               if (count_ff == '0) trun_in = 1'b0;
               out_load = 1'b1;
            end
         end
         ST_FILL: begin
            if (fill_cont) begin
               if (!hold_vld_ff || out_free) begin
                  if (hold_vld_ff) begin
                     out_load = 1'b1;
                     out_next = hold_ff;
                  end
                  mem_we      = 1'b1;
                  mem_wd      = '{offset: next_ff, plen: take, syn: syn, fin: fin_now};
                  fill_in     = fill_after;
                  if (fin_now) fin_in = 1'b1;
                  if (!trun_ff) begin
                     trun_in  = 1'b1;
                     tleft_in = tcur_ff;
                  end
                  outst_in    = outst_add;
                  next_in     = next_ff + {47'd0, seglen};
                  count_in    = count_ff + QCW'(1);
                  nseg_in     = nseg_ff + NSEG_W'(1);
                  hold_vld_in = 1'b1;
                  hold_in = status_result(17'd0, outst_add, retx_ff);
                  hold_in.last            = 1'b0;
                  hold_in.seg_valid       = 1'b1;
                  hold_in.seg_offset      = next_ff;
                  hold_in.seg_seqno       = next_ff[31:0] + csr.isn;
                  hold_in.seg_payload_len = take[10:0];
                  hold_in.seg_syn         = syn;
                  hold_in.seg_fin         = fin_now;
               end
            end else if (out_free) begin
               out_load = 1'b1;
               if (hold_vld_ff) begin
                  out_next      = hold_ff;
                  out_next.last = 1'b1;
               end
               hold_vld_in = 1'b0;
            end
         end
         default: ;
      endcase
      // timeout register write reloads a stopped timer
      if (csr.timeout_wr && !trun_ff) begin
         tcur_in  = {16'd0, csr.timeout_wdata};
         tleft_in = {16'd0, csr.timeout_wdata};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         next_ff     <= 64'd0;
         acked_ff    <= 64'd0;
         win_ff      <= 16'd1;
         outst_ff    <= 18'd0;
         fill_ff     <= '0;
         ended_ff    <= 1'b0;
         fin_ff      <= 1'b0;
         trun_ff     <= 1'b0;
         tleft_ff    <= {16'd0, TIMEOUT_RESET};
         tcur_ff     <= {16'd0, TIMEOUT_RESET};
         retx_ff     <= 16'd0;
         head_ff     <= '0;
         count_ff    <= '0;
         nseg_ff     <= '0;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         next_ff     <= next_in;
         acked_ff    <= acked_in;
         win_ff      <= win_in;
         outst_ff    <= outst_in;
         fill_ff     <= fill_in;
         ended_ff    <= ended_in;
         fin_ff      <= fin_in;
         trun_ff     <= trun_in;
         tleft_ff    <= tleft_in;
         tcur_ff     <= tcur_in;
         retx_ff     <= retx_in;
         head_ff     <= head_in;
         count_ff    <= count_in;
         nseg_ff     <= nseg_in;
         hold_vld_ff <= hold_vld_in;
         if (out_load) out_vld_ff <= 1'b1;
         else if (!out_stall) out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      off_ff  <= off_in;
      abs_ff  <= abs_in;
      wend_ff <= wend_in;
      hold_ff <= hold_in;
      if (out_load) out_ff <= out_next;
   end

   // segment queue memory, registered read at the head
   always_ff @(posedge clock) begin
      if (mem_we) mem[tail] <= mem_wd;
      mem_rd_ff <= mem[head_ff];
   end

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCW'(QUEUE_DEPTH))
      else $error("segment queue overflow");
   a_timer_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && count_ff == '0 |-> !trun_ff)
      else $error("timer running with empty segment queue");
   a_seg_limit: assert property (@(posedge clock) disable iff (reset)
      nseg_ff <= NSEG_W'(RESULT_LIMIT))
      else $error("too many segments in one fill");
   a_hold_in_fill: assert property (@(posedge clock) disable iff (reset)
      hold_vld_ff |-> state_ff == ST_FILL)
      else $error("held segment outside fill");
`endif

endmodule

// File: rtl/core/tcp_sender_window_retransmit_unit.sv
// top level of the tcp sender window / retransmit unit: register port, front end, engine
//
//  channel  direction  handshake                 payload
//  req      in         req_valid / req_stall     cmd, write_count, ack_seqno, ack_window, elapsed_ms
//  rsp      out        rsp_valid / rsp_stall     seg_*, accepted_bytes, in_flight, retx_count, last
//  csr      in/out     psel/penable/pwrite/pready paddr, pwdata, prdata
//
// write, end, send-empty, tick and unknown commands pass the idle and exec states of the engine
// an ack passes idle, exec, unwrap and apply, then reads and checks the queue head, popping each
// acked segment (one registered read of the queue memory each), or ends after apply beyond sent data
// fill window passes idle and exec, then cuts segments through the single queue write port
// reset is synchronous and clears all control state; the segment queue memory is not cleared
// a stalled result holds the engine, the 2-entry request queue keeps taking requests until full
module tcp_sender_window_retransmit_unit import tswr_pkg::*; #(
   parameter int MAX_PAYLOAD     = 1452,
   parameter int STREAM_CAPACITY = 65536,
   parameter int QUEUE_DEPTH     = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [16:0] req_write_count,
   input  logic [31:0] req_ack_seqno,
   input  logic [15:0] req_ack_window,
   input  logic [31:0] req_elapsed_ms,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_seg_valid,
   output logic [31:0] rsp_seg_seqno,
   output logic [63:0] rsp_seg_offset,
   output logic [10:0] rsp_seg_payload_len,
   output logic        rsp_seg_syn,
   output logic        rsp_seg_fin,
   output logic [16:0] rsp_accepted_bytes,
   output logic [17:0] rsp_in_flight,
   output logic [15:0] rsp_retx_count,
   output logic        rsp_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [31:0] isn_ff;
   logic [15:0] tmo_ff;
   logic        csr_wr;
   csr_type     csr;
   logic        item_valid;
   logic        item_pop;
   item_type    item;
   result_type  res;

   // register file: initial seqno at 0, initial timeout at 4
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, tmo_ff} : isn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         isn_ff <= 32'd0;
         tmo_ff <= TIMEOUT_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == REG_ISN) isn_ff <= pwdata;
         else tmo_ff <= pwdata[15:0];
      end
   end

   // timeout write also reaches the engine so a stopped timer reloads
   assign csr.timeout_wr    = csr_wr && (paddr[2] == REG_TIMEOUT);
   assign csr.timeout_wdata = pwdata[15:0];
   assign csr.isn           = isn_ff;
   assign csr.timeout       = tmo_ff;

   tswr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_write_count (req_write_count),
      .req_ack_seqno   (req_ack_seqno),
      .req_ack_window  (req_ack_window),
      .req_elapsed_ms  (req_elapsed_ms),
      .item_pop        (item_pop),
      .item_valid      (item_valid),
      .item            (item)
   );

   tswr_engine #(
      .MAX_PAYLOAD     (MAX_PAYLOAD),
      .STREAM_CAPACITY (STREAM_CAPACITY),
      .QUEUE_DEPTH     (QUEUE_DEPTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_data   (res)
   );

   // result fields
   assign rsp_seg_valid       = res.seg_valid;
   assign rsp_seg_seqno       = res.seg_seqno;
   assign rsp_seg_offset      = res.seg_offset;
   assign rsp_seg_payload_len = res.seg_payload_len;
   assign rsp_seg_syn         = res.seg_syn;
   assign rsp_seg_fin         = res.seg_fin;
   assign rsp_accepted_bytes  = res.accepted_bytes;
   assign rsp_in_flight       = res.in_flight;
   assign rsp_retx_count      = res.retx_count;
   assign rsp_last            = res.last;

`ifndef NO_ASSERTIONS
   a_last_seg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_seg_valid |-> rsp_last)
      else $error("status result without last");
   a_acc_write_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_seg_valid |-> rsp_accepted_bytes == 17'd0)
      else $error("segment result carries accepted bytes");
   a_inflight_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_in_flight <= INFLIGHT_MAX)
      else $error("in flight count above saturation");
`endif

endmodule

// File: dv/testbench.sv
// self-checking testbench for the tcp sender window / retransmit unit
`timescale 1ns / 1ps

module testbench;
   import tswr_pkg::*;

   // command codes the block does not know, a status result is all they give
   localparam logic [2:0] CMD_SPARE6 = 3'd6;
   localparam logic [2:0] CMD_SPARE7 = 3'd7;
   localparam logic [2:0] ADDR_ISN     = 3'd0;   // register 0 at byte 0
   localparam logic [2:0] ADDR_TIMEOUT = 3'd4;   // register 1 at byte 4
   localparam int SEG_MAX      = 1452;
   localparam int BUF_CAP      = 65536;
   localparam int PQ_DEPTH     = 64;
   localparam int WATCHDOG     = 5000;
   localparam int SETTLE       = 40;
   localparam int HOLD_CYCLES  = 400;
   localparam longint unsigned SPAN = 64'h1_0000_0000;
   localparam longint unsigned HALF = 64'h8000_0000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = CMD_WRITE;
   logic [16:0] req_write_count = '0;
   logic [31:0] req_ack_seqno = '0;
   logic [15:0] req_ack_window = '0;
   logic [31:0] req_elapsed_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_seg_valid;
   logic [31:0] rsp_seg_seqno;
   logic [63:0] rsp_seg_offset;
   logic [10:0] rsp_seg_payload_len;
   logic        rsp_seg_syn;
   logic        rsp_seg_fin;
   logic [16:0] rsp_accepted_bytes;
   logic [17:0] rsp_in_flight;
   logic [15:0] rsp_retx_count;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   tcp_sender_window_retransmit_unit DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one request as the sender offers it, with an optional hand-typed result
   typedef struct {
      logic [2:0]  cmd;
      logic [16:0] wcount;
      logic [31:0] ackno;
      logic [15:0] window;
      logic [31:0] elapsed;
      bit          pinned;
      result_type  want;
   } request_row;

   // ------------------------------------------------------------------
   // sender model state, mirrors the block's control state
   // ------------------------------------------------------------------
   int unsigned     cfg_isn, cfg_rto;
   longint unsigned snd_next, snd_acked;
   int unsigned     peer_win, infl, buf_fill, retx_run, rto_left, rto_cur;
   bit              eof_seen, fin_out, rto_on;
   qentry_type      pq [PQ_DEPTH];
   int unsigned     pq_head, pq_count;

   result_type      seg_expect [$];   // results still owed by the block
   bit              pin_have [$];     // per offered request: typed result present
   result_type      pin_want [$];
   int              errors = 0;
   int              idle_cycles = 0;
   bit              jitter = 1'b1;    // random gaps and stalls on/off
   bit              hold_rsp = 1'b0;  // one long receiver hold-off

   function automatic logic [31:0] wrap_abs(longint unsigned abs);
      return 32'(abs + longint'(cfg_isn));
   endfunction

   function automatic longint unsigned unwrap_ack(logic [31:0] w, longint unsigned cp);
      logic [31:0] off;
      longint unsigned cand;
      off  = w - cfg_isn;
      cand = (cp & ~(SPAN - 1)) + longint'(off);
      if (cand > cp) begin
         if (cand - cp > HALF && cand >= SPAN) cand -= SPAN;
      end else begin
         if (cp - cand > HALF && cand <= 64'hFFFF_FFFF_FFFF_FFFF - SPAN) cand += SPAN;
      end
      return cand;
   endfunction

   function automatic result_type seg_result(qentry_type e, logic lst);
      result_type r;
      r = '0;
      r.seg_valid       = 1'b1;
      r.seg_seqno       = wrap_abs(e.offset);
      r.seg_offset      = e.offset;
      r.seg_payload_len = e.plen[10:0];
      r.seg_syn         = e.syn;
      r.seg_fin         = e.fin;
      r.in_flight       = infl[17:0];
      r.retx_count      = retx_run[15:0];
      r.last            = lst;
      return r;
   endfunction

   function automatic result_type status_now(int unsigned acc);
      result_type r;
      r = '0;
      r.accepted_bytes = acc[16:0];
      r.in_flight      = infl[17:0];
      r.retx_count     = retx_run[15:0];
      r.last           = 1'b1;
      return r;
   endfunction

   // cut segments into the window, one result each
   function automatic void cut_segments();
      longint unsigned win, stop, room, take, seglen;
      qentry_type e;
      int n;
      win  = peer_win > 0 ? peer_win : 1;
      stop = snd_acked + win;
      n    = 0;
      while (!fin_out && snd_next < stop && n < RESULT_LIMIT && pq_count < PQ_DEPTH &&
             (buf_fill > 0 || snd_next == 0 || eof_seen)) begin
         room     = stop - snd_next;
         e        = '0;
         e.offset = snd_next;
         e.syn    = snd_next == 0;
         take     = room - e.syn;
         if (take > buf_fill) take = buf_fill;
         if (take > SEG_MAX) take = SEG_MAX;
         buf_fill -= int'(take);
         e.plen   = 16'(take);
         seglen   = take + e.syn;
         if (seglen < room && eof_seen && buf_fill == 0) begin
            e.fin   = 1'b1;
            seglen += 1;
            fin_out = 1'b1;
         end
         if (!rto_on) begin
            rto_on   = 1'b1;
            rto_left = rto_cur;
         end
         infl = infl + int'(seglen) > 131072 ? 131072 : infl + int'(seglen);
         snd_next += seglen;
         pq[(pq_head + pq_count) % PQ_DEPTH] = e;
         pq_count++;
         seg_expect.push_back(seg_result(e, 1'b0));
         n++;
      end
      if (n == 0) seg_expect.push_back(status_now(0));
      else seg_expect[$].last = 1'b1;
   endfunction

   function automatic void take_ack(logic [31:0] ackno, logic [15:0] window);
      longint unsigned abs;
      int unsigned len;
      abs = unwrap_ack(ackno, snd_next);
      if (abs > snd_next) return;   // acks data never sent
      snd_acked = abs;
      peer_win  = window;
      retx_run  = 0;
      while (pq_count > 0) begin
         len = pq[pq_head].plen + pq[pq_head].syn + pq[pq_head].fin;
         if (pq[pq_head].offset + len > abs) break;
         rto_left = cfg_rto;
         rto_cur  = cfg_rto;
         infl     = infl > len ? infl - len : 0;
         pq_head  = (pq_head + 1) % PQ_DEPTH;
         pq_count--;
      end
      if (pq_count == 0) rto_on = 1'b0;
   endfunction

   // works out every result one accepted request causes
   function automatic void predict_request(logic [2:0] cmd, logic [16:0] wc,
                                           logic [31:0] ackno, logic [15:0] window,
                                           logic [31:0] elapsed);
      int unsigned room, acc;
      case (cmd)
         CMD_WRITE: begin
            room = BUF_CAP - buf_fill;
            acc  = eof_seen ? 0 : (wc < room ? wc : room);
            buf_fill += acc;
            seg_expect.push_back(status_now(acc));
         end
         CMD_END: begin
            eof_seen = 1'b1;
            seg_expect.push_back(status_now(0));
         end
         CMD_ACK: begin
            take_ack(ackno, window);
            seg_expect.push_back(status_now(0));
         end
         CMD_TICK: begin
            if (rto_on && pq_count > 0 && rto_left <= elapsed) begin
               // timer fired: resend the oldest, back off only with an open window
               if (peer_win != 0) begin
                  if (retx_run < 16'hFFFF) retx_run++;
                  rto_cur = rto_cur > 32'h7FFF_FFFF ? 32'hFFFF_FFFF : rto_cur * 2;
               end
               rto_left = rto_cur;
               seg_expect.push_back(seg_result(pq[pq_head], 1'b1));
            end else begin
               if (rto_on && pq_count > 0) rto_left -= elapsed;
               seg_expect.push_back(status_now(0));
            end
         end
         CMD_FILL: cut_segments();
         CMD_EMPTY: begin
            qentry_type e;
            e = '0;
            e.offset = snd_next;
            seg_expect.push_back(seg_result(e, 1'b1));
         end
         default: seg_expect.push_back(status_now(0));
      endcase
   endfunction

   function automatic string field_diffs(result_type a, result_type e);
      string s;
      s = "";
      if (a.seg_valid !== e.seg_valid) s = {s, " seg_valid"};
      if (a.seg_seqno !== e.seg_seqno) s = {s, " seg_seqno"};
      if (a.seg_offset !== e.seg_offset) s = {s, " seg_offset"};
      if (a.seg_payload_len !== e.seg_payload_len) s = {s, " seg_payload_len"};
      if (a.seg_syn !== e.seg_syn) s = {s, " seg_syn"};
      if (a.seg_fin !== e.seg_fin) s = {s, " seg_fin"};
      if (a.accepted_bytes !== e.accepted_bytes) s = {s, " accepted_bytes"};
      if (a.in_flight !== e.in_flight) s = {s, " in_flight"};
      if (a.retx_count !== e.retx_count) s = {s, " retx_count"};
      if (a.last !== e.last) s = {s, " last"};
      return s;
   endfunction

   function automatic void note_error(string msg);
      errors++;
      if (errors <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   // ------------------------------------------------------------------
   // monitor: predict on each accepted request, check each accepted result
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      result_type got, want;
      string diffs;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            idle_cycles = 0;
            predict_request(req_cmd, req_write_count, req_ack_seqno, req_ack_window,
                            req_elapsed_ms);
            // a hand-typed result stands in for the predicted one
            if (pin_have.size() > 0) begin
               if (pin_have.pop_front()) seg_expect[$] = pin_want.pop_front();
               else void'(pin_want.pop_front());
            end
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            got = {rsp_seg_valid, rsp_seg_seqno, rsp_seg_offset, rsp_seg_payload_len,
                   rsp_seg_syn, rsp_seg_fin, rsp_accepted_bytes, rsp_in_flight,
                   rsp_retx_count, rsp_last};
            if (seg_expect.size() == 0) begin
               note_error($sformatf("unexpected result %p", got));
            end else begin
               want  = seg_expect.pop_front();
               diffs = field_diffs(got, want);
               if (diffs != "")
                  note_error($sformatf("fields%s\n  expected %p\n  actual   %p", diffs,
                                       want, got));
            end
         end
         if (idle_cycles >= WATCHDOG) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // receiver: random stall bursts, plus one long hold-off on request
   // ------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_stall <= 1'b0;
         end else if (jitter && $urandom_range(5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(8, 1) - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------
   task automatic offer(request_row r);
      if (jitter && $urandom_range(4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(negedge clock);
      end
      pin_have.push_back(r.pinned);
      pin_want.push_back(r.want);
      req_cmd         <= r.cmd;
      req_write_count <= r.wcount;
      req_ack_seqno   <= r.ackno;
      req_ack_window  <= r.window;
      req_elapsed_ms  <= r.elapsed;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      @(negedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_ISN) begin
         cfg_isn = data;
      end else begin
         cfg_rto = data[15:0];
         if (!rto_on) begin
            rto_cur  = cfg_rto;
            rto_left = cfg_rto;
         end
      end
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_check(logic [2:0] addr, logic [31:0] want);
      psel <= 1'b1; pwrite <= 1'b0; paddr <= addr; penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== want)
         note_error($sformatf("register %0d reads %h, expected %h", addr, prdata, want));
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
      @(negedge clock);
   endtask

   // registers change only with the block quiet
   task automatic drain();
      req_valid <= 1'b0;
      wait (seg_expect.size() == 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   function automatic request_row row(logic [2:0] cmd, logic [16:0] wc = 0,
                                      logic [31:0] ackno = 0, logic [15:0] window = 0,
                                      logic [31:0] elapsed = 0);
      request_row r;
      r.cmd = cmd; r.wcount = wc; r.ackno = ackno; r.window = window; r.elapsed = elapsed;
      r.pinned = 1'b0;
      r.want = '0;
      return r;
   endfunction

   function automatic request_row typed(request_row r, logic sv, logic [31:0] seq,
                                        logic [10:0] plen, logic syn, int unsigned acc,
                                        int unsigned fl, int unsigned retx);
      r.pinned = 1'b1;
      r.want   = '{seg_valid: sv, seg_seqno: seq, seg_offset: 64'(seq), seg_payload_len: plen,
                   seg_syn: syn, seg_fin: 1'b0, accepted_bytes: acc[16:0],
                   in_flight: fl[17:0], retx_count: retx[15:0], last: 1'b1};
      return r;
   endfunction

   // random request, mostly well formed against the current sender state
   function automatic request_row random_request();
      int pick;
      longint unsigned span;
      request_row r;
      pick = $urandom_range(99);
      r = row(CMD_WRITE);
      if (pick < 22) begin
         r.cmd    = CMD_WRITE;
         r.wcount = $urandom_range(7) == 0 ? 17'd65536 :
                    ($urandom_range(3) == 0 ? 17'($urandom_range(65536)) :
                                              17'($urandom_range(3000)));
      end else if (pick < 47) begin
         r.cmd = CMD_FILL;
      end else if (pick < 72) begin
         r.cmd    = CMD_ACK;
         span     = snd_next - snd_acked;
         r.ackno  = $urandom_range(9) == 0 ? $urandom() :
                    wrap_abs(snd_acked + (span > 0 ? $urandom_range(32'(span)) : 0));
         r.window = $urandom_range(5) == 0 ? 16'($urandom()) :
                    ($urandom_range(7) == 0 ? 16'd0 : 16'($urandom_range(6000)));
      end else if (pick < 90) begin
         r.cmd     = CMD_TICK;
         r.elapsed = $urandom_range(5) == 0 ? $urandom() :
                     ($urandom_range(2) == 0 ? rto_left : $urandom_range(rto_cur));
      end else if (pick < 96) begin
         r.cmd = CMD_EMPTY;
      end else begin
         r.cmd = pick[0] ? CMD_SPARE6 : CMD_SPARE7;
         r.wcount = $urandom(); r.ackno = $urandom(); r.elapsed = $urandom();
      end
      return r;
   endfunction

   task automatic random_burst(int n);
      repeat (n) offer(random_request());
   endtask

   initial begin
      request_row steps [$];
      // model reset
      cfg_isn = 0; cfg_rto = TIMEOUT_RESET;
      snd_next = 0; snd_acked = 0; peer_win = 1; infl = 0; buf_fill = 0; retx_run = 0;
      rto_left = cfg_rto; rto_cur = cfg_rto;
      eof_seen = 0; fin_out = 0; rto_on = 0; pq_head = 0; pq_count = 0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      csr_check(ADDR_ISN, 32'd0);
      csr_check(ADDR_TIMEOUT, 32'(TIMEOUT_RESET));

      // directed part with reset registers: isn 0, timeout 1000
      steps.push_back(typed(row(CMD_WRITE, 0), 0, 0, 0, 0, 0, 0, 0));
      steps.push_back(typed(row(CMD_FILL), 1, 0, 0, 1, 0, 1, 0));        // syn alone
      steps.push_back(typed(row(CMD_WRITE, 65536), 0, 0, 0, 0, 65536, 1, 0));
      steps.push_back(typed(row(CMD_WRITE, 100), 0, 0, 0, 0, 0, 1, 0));  // buffer full
      steps.push_back(typed(row(CMD_TICK, 0, 0, 0, 999), 0, 0, 0, 0, 0, 1, 0));
      steps.push_back(typed(row(CMD_TICK, 0, 0, 0, 1), 1, 0, 0, 1, 0, 1, 1));
      steps.push_back(typed(row(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF), 1, 0, 0, 1, 0, 1, 2));
      // ack past sent data is dropped, retransmit count survives
      steps.push_back(typed(row(CMD_ACK, 0, 5, 100), 0, 0, 0, 0, 0, 1, 2));
      steps.push_back(typed(row(CMD_ACK, 0, 1, 16'hFFFF), 0, 0, 0, 0, 0, 0, 0));
      steps.push_back(typed(row(CMD_ACK, 0, 1, 16'hFFFF), 0, 0, 0, 0, 0, 0, 0));
      steps.push_back(row(CMD_FILL));                                    // fills the whole window
      steps.push_back(row(CMD_FILL));
      steps.push_back(row(CMD_ACK, 0, 20000, 0));                        // zero window
      steps.push_back(row(CMD_FILL));                                    // zero window as one
      steps.push_back(row(CMD_TICK, 0, 0, 0, 32'hFFFF_FFFF));            // no backoff
      steps.push_back(row(CMD_EMPTY));
      steps.push_back(row(CMD_SPARE6, 17'h1FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
      steps.push_back(row(CMD_SPARE7));
      steps.push_back(row(CMD_ACK, 0, 32'hFFFF_FFFF, 16'hFFFF));         // beyond sent, dropped
      steps.push_back(row(CMD_ACK, 0, 32'h8000_0000, 16'd2000));
      foreach (steps[i]) offer(steps[i]);
      drain();

      // smallest timeout, isn at the top of the space
      csr_write(ADDR_ISN, 32'hFFFF_FFFF);
      csr_write(ADDR_TIMEOUT, 32'd1);
      csr_check(ADDR_ISN, 32'hFFFF_FFFF);
      random_burst(30);
      drain();

      // largest timeout, half-space isn, long receiver hold-off while fills pile up
      csr_write(ADDR_ISN, 32'h8000_0000);
      csr_write(ADDR_TIMEOUT, 32'd65535);
      csr_check(ADDR_TIMEOUT, 32'd65535);
      offer(row(CMD_WRITE, 65536));
      offer(row(CMD_ACK, 0, wrap_abs(snd_next), 16'hFFFF));
      hold_rsp = 1'b1;
      repeat (6) offer(row(CMD_FILL));
      random_burst(20);
      drain();

      // random registers, then close the stream with no idling
      csr_write(ADDR_ISN, $urandom());
      csr_write(ADDR_TIMEOUT, 32'($urandom_range(65535, 1)));
      random_burst(20);
      jitter = 1'b0;
      offer(row(CMD_END));
      offer(row(CMD_ACK, 0, wrap_abs(snd_next), 16'hFFFF));
      offer(row(CMD_FILL));
      offer(row(CMD_FILL));
      offer(row(CMD_WRITE, 500));                                        // after end input
      random_burst(12);
      req_valid <= 1'b0;

      wait (seg_expect.size() == 0);
      repeat (SETTLE) @(negedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
